/* src/tlpc_pkg.sv */
`timescale 1ns / 1ps
package tlpc_pkg;

	// Field and datapath widths
	localparam int COORD_W   = 20;
	localparam int FRAC_BITS = 8;
	localparam int GRID_W    = 8;
	localparam int COUNT_W   = 16;
	localparam logic [GRID_W-1:0] GRID_MAX_RST = GRID_W'(99);

	// Grid point scaled to fixed point (unsigned)
	localparam int OX_W   = GRID_W + FRAC_BITS;
	// Edge vector: difference of two coordinates
	localparam int EDGE_W = COORD_W + 1;
	// Point minus vertex
	localparam int DIFF_W = ((COORD_W > OX_W + 1) ? COORD_W : OX_W + 1) + 1;
	// One product of the cross term, and the cross difference
	localparam int PROD_W  = EDGE_W + DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	localparam int NUM_EDGES = 3;

	// Triangle held for the whole scan
	typedef struct packed {
		logic [NUM_EDGES-1:0][COORD_W-1:0] vx;
		logic [NUM_EDGES-1:0][COORD_W-1:0] vy;
		logic [NUM_EDGES-1:0][EDGE_W-1:0]  ex;
		logic [NUM_EDGES-1:0][EDGE_W-1:0]  ey;
	} tri_t;

	// One grid point beat from the scanner
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              dummy;
		logic [GRID_W-1:0] x;
		logic [GRID_W-1:0] y;
	} point_t;

	// Edge test result of one grid point
	typedef struct packed {
		logic valid;
		logic last;
		logic dummy;
		logic pos;
		logic neg;
	} sign_t;

endpackage

/* src/tlpc_scan.sv */
`timescale 1ns / 1ps
module tlpc_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        adv,
	input  logic [tlpc_pkg::GRID_W-1:0] grid_max,
	output tlpc_pkg::point_t            pt
);

	logic                        active_q;
	logic [tlpc_pkg::GRID_W-1:0] scan_x_q;
	logic [tlpc_pkg::GRID_W-1:0] scan_y_q;
	logic                        empty_grid;
	logic                        x_end;
	logic                        y_end;

	assign empty_grid = (grid_max == '0);
	assign x_end      = (scan_x_q == grid_max);
	assign y_end      = (scan_y_q == grid_max);

	// Current point beat
	always_comb begin
		pt.valid = active_q;
		pt.last  = empty_grid || (x_end && y_end);
		pt.dummy = empty_grid;
		pt.x     = scan_x_q;
		pt.y     = scan_y_q;
	end

	// Row-major walk over the grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			scan_x_q <= tlpc_pkg::GRID_W'(1);
			scan_y_q <= tlpc_pkg::GRID_W'(1);
		end else if (start) begin
			active_q <= 1'b1;
			scan_x_q <= tlpc_pkg::GRID_W'(1);
			scan_y_q <= tlpc_pkg::GRID_W'(1);
		end else if (active_q && adv) begin
			if (pt.last) begin
				active_q <= 1'b0;
				scan_x_q <= tlpc_pkg::GRID_W'(1);
				scan_y_q <= tlpc_pkg::GRID_W'(1);
			end else if (x_end) begin
				scan_x_q <= tlpc_pkg::GRID_W'(1);
				scan_y_q <= scan_y_q + tlpc_pkg::GRID_W'(1);
			end else begin
				scan_x_q <= scan_x_q + tlpc_pkg::GRID_W'(1);
			end
		end
	end

endmodule

/* src/tlpc_edge.sv */
`timescale 1ns / 1ps
module tlpc_edge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  tlpc_pkg::tri_t   tri_in,
	input  tlpc_pkg::point_t pt,
	output tlpc_pkg::sign_t  sgn
);

	localparam int NE = tlpc_pkg::NUM_EDGES;

	// Stage 1: point minus edge start vertex
	logic                                   v_s1, last_s1, dummy_s1;
	logic signed [tlpc_pkg::DIFF_W-1:0]     dox_s1 [NE];
	logic signed [tlpc_pkg::DIFF_W-1:0]     doy_s1 [NE];
	// Stage 2: the two products of each cross term
	logic                                   v_s2, last_s2, dummy_s2;
	logic signed [tlpc_pkg::PROD_W-1:0]     p_s2 [NE];
	logic signed [tlpc_pkg::PROD_W-1:0]     q_s2 [NE];
	// Stage 3: sign summary
	logic                                   v_s3, last_s3, dummy_s3, pos_s3, neg_s3;

	logic signed [tlpc_pkg::DIFF_W-1:0]     ox, oy;
	logic signed [tlpc_pkg::CROSS_W-1:0]    cross_val [NE];
	logic [NE-1:0]                          gt, lt;

	// Grid point in fixed point
	assign ox = $signed(tlpc_pkg::DIFF_W'({pt.x, {tlpc_pkg::FRAC_BITS{1'b0}}}));
	assign oy = $signed(tlpc_pkg::DIFF_W'({pt.y, {tlpc_pkg::FRAC_BITS{1'b0}}}));

	// Valid and tag bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pt.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1 datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1  <= pt.last;
			dummy_s1 <= pt.dummy;
			for (int k = 0; k < NE; k++) begin
				dox_s1[k] <= ox - tlpc_pkg::DIFF_W'($signed(tri_in.vx[k]));
				doy_s1[k] <= oy - tlpc_pkg::DIFF_W'($signed(tri_in.vy[k]));
			end
		end
	end

	// Stage 2 datapath: edge x times point dy, edge y times point dx
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2  <= last_s1;
			dummy_s2 <= dummy_s1;
			for (int k = 0; k < NE; k++) begin
				p_s2[k] <= tlpc_pkg::PROD_W'($signed(tri_in.ex[k]) * doy_s1[k]);
				q_s2[k] <= tlpc_pkg::PROD_W'($signed(tri_in.ey[k]) * dox_s1[k]);
			end
		end
	end

	// Cross product signs
	always_comb begin
		for (int k = 0; k < NE; k++) begin
			cross_val[k] = tlpc_pkg::CROSS_W'(p_s2[k]) - tlpc_pkg::CROSS_W'(q_s2[k]);
			gt[k]        = (cross_val[k] > 0);
			lt[k]        = (cross_val[k] < 0);
		end
	end

	// Stage 3 datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3  <= last_s2;
			dummy_s3 <= dummy_s2;
			pos_s3   <= |gt;
			neg_s3   <= |lt;
		end
	end

	always_comb begin
		sgn.valid = v_s3;
		sgn.last  = last_s3;
		sgn.dummy = dummy_s3;
		sgn.pos   = pos_s3;
		sgn.neg   = neg_s3;
	end

endmodule

/* src/tlpc_count.sv */
`timescale 1ns / 1ps
module tlpc_count (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tlpc_pkg::sign_t              sgn,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [tlpc_pkg::COUNT_W-1:0] point_count,
	output logic                         adv,
	output logic                         done
);

	logic                         out_valid_q;
	logic [tlpc_pkg::COUNT_W-1:0] out_count_q;
	logic [tlpc_pkg::COUNT_W-1:0] hit_count_q;
	logic [tlpc_pkg::COUNT_W-1:0] hit_next;
	logic                         hit;

	// Pipeline moves unless a finished count is held by the consumer
	assign adv  = !out_valid_q || !out_stall;
	assign done = adv && sgn.valid && sgn.last;

	// Inside or on the boundary: no mix of positive and negative signs, and not a dummy point
	assign hit      = !sgn.dummy && !(sgn.pos && sgn.neg);
	assign hit_next = hit_count_q + tlpc_pkg::COUNT_W'(hit);

	// Running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_count_q <= '0;
		end else if (adv && sgn.valid) begin
			hit_count_q <= sgn.last ? '0 : hit_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_count_q <= hit_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign point_count = out_count_q;

endmodule

/* src/triangle_lattice_point_counter.sv */
`timescale 1ns / 1ps
// Channel | Handshake              | Beat
// in      | in_valid / in_stall    | ax, ay, bx, by_coord, cx, cy (Q.8 signed)
// out     | out_valid / out_stall  | point_count
// cfg     | cfg_valid / cfg_ready  | grid_max
//
// The scan feeds one grid point per cycle into the edge pipeline, unless a held
// output stalls it, walking grid_max * grid_max points (a single dummy point
// when grid_max is 0); the count follows through the pipeline stages.
// in_stall stays high from accepting a triangle until its count is loaded
// into the output register; the next triangle may then enter while it waits.
// A held output stalls the point pipeline; nothing is dropped.
// Reset sets grid_max to 99 and empties the pipeline and output register.
module triangle_lattice_point_counter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [tlpc_pkg::COORD_W-1:0] ax,
	input  logic signed [tlpc_pkg::COORD_W-1:0] ay,
	input  logic signed [tlpc_pkg::COORD_W-1:0] bx,
	input  logic signed [tlpc_pkg::COORD_W-1:0] by_coord,
	input  logic signed [tlpc_pkg::COORD_W-1:0] cx,
	input  logic signed [tlpc_pkg::COORD_W-1:0] cy,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tlpc_pkg::COUNT_W-1:0]        point_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tlpc_pkg::GRID_W-1:0]         grid_max
);

	logic                        busy_q;
	logic [tlpc_pkg::GRID_W-1:0] grid_max_q;
	tlpc_pkg::tri_t              tri_q;
	tlpc_pkg::point_t            pt;
	tlpc_pkg::sign_t             sgn;
	logic                        accept;
	logic                        adv;
	logic                        done;

	assign accept    = in_valid && !busy_q;
	assign in_stall  = busy_q;
	assign cfg_ready = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_max_q <= tlpc_pkg::GRID_MAX_RST;
		end else if (cfg_valid) begin
			grid_max_q <= grid_max;
		end
	end

	// Busy from accept until the count is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// Triangle capture: vertices and edge vectors AB, BC, CA
	always_ff @(posedge clk) begin
		if (accept) begin
			tri_q.vx[0] <= ax;
			tri_q.vx[1] <= bx;
			tri_q.vx[2] <= cx;
			tri_q.vy[0] <= ay;
			tri_q.vy[1] <= by_coord;
			tri_q.vy[2] <= cy;
			tri_q.ex[0] <= tlpc_pkg::EDGE_W'(bx) - tlpc_pkg::EDGE_W'(ax);
			tri_q.ex[1] <= tlpc_pkg::EDGE_W'(cx) - tlpc_pkg::EDGE_W'(bx);
			tri_q.ex[2] <= tlpc_pkg::EDGE_W'(ax) - tlpc_pkg::EDGE_W'(cx);
			tri_q.ey[0] <= tlpc_pkg::EDGE_W'(by_coord) - tlpc_pkg::EDGE_W'(ay);
			tri_q.ey[1] <= tlpc_pkg::EDGE_W'(cy) - tlpc_pkg::EDGE_W'(by_coord);
			tri_q.ey[2] <= tlpc_pkg::EDGE_W'(ay) - tlpc_pkg::EDGE_W'(cy);
		end
	end

	tlpc_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.adv      (adv),
		.grid_max (grid_max_q),
		.pt       (pt)
	);

	tlpc_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tri_in (tri_q),
		.pt     (pt),
		.sgn    (sgn)
	);

	tlpc_count u_count (
		.clk         (clk),
		.arst_n      (arst_n),
		.sgn         (sgn),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.point_count (point_count),
		.adv         (adv),
		.done        (done)
	);

endmodule

/* src/tlpc_checker.sv */
`timescale 1ns / 1ps
module tlpc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [tlpc_pkg::COUNT_W-1:0]        point_count
);

	localparam logic [tlpc_pkg::COUNT_W-1:0] MAX_COUNT = tlpc_pkg::COUNT_W'(65025);

	// A held result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_count))
		else $error("held count changed or dropped");

	// An accepted triangle makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// A count cannot appear right after a triangle enters
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("count appeared too early");

	// Count never exceeds the full grid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> point_count <= MAX_COUNT)
		else $error("count out of range");

endmodule

bind triangle_lattice_point_counter tlpc_checker u_tlpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.point_count (point_count)
);

/* tb/lattice_count_checker.sv */
`timescale 1ns / 1ps
module lattice_count_checker
	import tlpc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic signed [COORD_W-1:0] ax,
	input  logic signed [COORD_W-1:0] ay,
	input  logic signed [COORD_W-1:0] bx,
	input  logic signed [COORD_W-1:0] by_coord,
	input  logic signed [COORD_W-1:0] cx,
	input  logic signed [COORD_W-1:0] cy,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [COUNT_W-1:0]        point_count,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [GRID_W-1:0]         grid_max,
	output int                        mismatches,
	output int                        pending,
	output int                        counts_seen
);

	// local copy of the grid register, tracked from cfg beats
	logic [GRID_W-1:0]  grid_limit = GRID_MAX_RST;
	logic [COUNT_W-1:0] expected_counts[$];

	// signed cross product of edge P->Q with P->O
	function automatic longint edge_cross(input longint px, input longint py,
			input longint qx, input longint qy, input longint ox, input longint oy);
		return (qx - px) * (oy - py) - (qy - py) * (ox - px);
	endfunction

	// walk the grid; a point hits unless the edge signs disagree
	function automatic logic [COUNT_W-1:0] count_lattice_hits(input longint x0,
			input longint y0, input longint x1, input longint y1,
			input longint x2, input longint y2, input int g);
		longint             ox;
		longint             oy;
		longint             s0;
		longint             s1;
		longint             s2;
		logic               pos;
		logic               neg;
		logic [COUNT_W-1:0] hits;
		hits = '0;
		for (int y = 1; y <= g; y++) begin
			for (int x = 1; x <= g; x++) begin
				ox  = longint'(x) << FRAC_BITS;
				oy  = longint'(y) << FRAC_BITS;
				s0  = edge_cross(x0, y0, x1, y1, ox, oy);
				s1  = edge_cross(x1, y1, x2, y2, ox, oy);
				s2  = edge_cross(x2, y2, x0, y0, ox, oy);
				pos = (s0 > 0) || (s1 > 0) || (s2 > 0);
				neg = (s0 < 0) || (s1 < 0) || (s2 < 0);
				if (!(pos && neg))
					hits = hits + COUNT_W'(1);
			end
		end
		return hits;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// sample all channels on the rising edge
	always @(posedge clk) begin
		logic [COUNT_W-1:0] want;
		if (!arst_n) begin
			mismatches  = 0;
			pending     = 0;
			counts_seen = 0;
		end else begin
			// count beat against the oldest prediction
			if (out_valid && !out_stall) begin
				counts_seen++;
				if (expected_counts.size() == 0) begin
					report_mismatch($sformatf("count %0d with none expected", point_count));
				end else begin
					want = expected_counts.pop_front();
					if (point_count !== want)
						report_mismatch($sformatf("point_count %0d, expected %0d",
							point_count, want));
				end
			end
			if (cfg_valid && cfg_ready)
				grid_limit = grid_max;
			// triangle beat: predict its count with the current grid
			if (in_valid && !in_stall)
				expected_counts.push_back(count_lattice_hits(longint'(ax), longint'(ay),
					longint'(bx), longint'(by_coord), longint'(cx), longint'(cy),
					int'(grid_limit)));
			pending = expected_counts.size();
		end
	end

endmodule

/* tb/tb_triangle_lattice_point_counter.sv */
`timescale 1ns / 1ps
module tb_triangle_lattice_point_counter;
	import tlpc_pkg::*;

	localparam int Q = 1 << FRAC_BITS;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [COORD_W-1:0] ax;
	logic signed [COORD_W-1:0] ay;
	logic signed [COORD_W-1:0] bx;
	logic signed [COORD_W-1:0] by_coord;
	logic signed [COORD_W-1:0] cx;
	logic signed [COORD_W-1:0] cy;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [COUNT_W-1:0]        point_count;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [GRID_W-1:0]         grid_max;

	int mismatches;
	int pending;
	int counts_seen;
	int send_idle_pct;
	int recv_stall_pct;
	int triangles_sent;
	int grid_writes;

	triangle_lattice_point_counter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ax         (ax),
		.ay         (ay),
		.bx         (bx),
		.by_coord   (by_coord),
		.cx         (cx),
		.cy         (cy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.point_count(point_count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.grid_max   (grid_max)
	);

	lattice_count_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ax         (ax),
		.ay         (ay),
		.bx         (bx),
		.by_coord   (by_coord),
		.cx         (cx),
		.cy         (cy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.point_count(point_count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.grid_max   (grid_max),
		.mismatches (mismatches),
		.pending    (pending),
		.counts_seen(counts_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#30_000_000;
		$display("FAIL");
		$finish;
	end

	// receiver stalls at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	// one triangle beat; entered and left at a falling edge, valid left high
	task automatic send_triangle(input int a_x, input int a_y, input int b_x,
			input int b_y, input int c_x, input int c_y);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		ax       <= COORD_W'(a_x);
		ay       <= COORD_W'(a_y);
		bx       <= COORD_W'(b_x);
		by_coord <= COORD_W'(b_y);
		cx       <= COORD_W'(c_x);
		cy       <= COORD_W'(c_y);
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		triangles_sent++;
	endtask

	// drain all counts, then a short pause for the pipeline
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_grid(input int g);
		wait_drained();
		cfg_valid <= 1'b1;
		grid_max  <= GRID_W'(g);
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		grid_writes++;
	endtask

	function automatic int near_coord(input int g);
		return int'($urandom_range(0, (g + 4) * Q)) - 2 * Q;
	endfunction

	// mostly triangles over the grid, some lattice-aligned, collinear or wild
	task automatic send_random_triangle(input int g);
		int kind;
		int px;
		int py;
		int dx;
		int dy;
		int k1;
		int k2;
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			send_triangle(near_coord(g), near_coord(g), near_coord(g),
				near_coord(g), near_coord(g), near_coord(g));
		end else if (kind < 70) begin
			send_triangle($urandom_range(0, g + 2) * Q, $urandom_range(0, g + 2) * Q,
				$urandom_range(0, g + 2) * Q, $urandom_range(0, g + 2) * Q,
				$urandom_range(0, g + 2) * Q, $urandom_range(0, g + 2) * Q);
		end else if (kind < 85) begin
			px = $urandom_range(0, g + 1) * Q;
			py = $urandom_range(0, g + 1) * Q;
			dx = int'($urandom_range(0, 6)) * Q - 3 * Q;
			dy = int'($urandom_range(0, 6)) * Q - 3 * Q;
			k1 = int'($urandom_range(0, 6)) - 3;
			k2 = int'($urandom_range(0, 6)) - 3;
			send_triangle(px, py, px + k1 * dx, py + k1 * dy, px + k2 * dx, py + k2 * dy);
		end else begin
			send_triangle(int'($urandom()), int'($urandom()), int'($urandom()),
				int'($urandom()), int'($urandom()), int'($urandom()));
		end
	endtask

	// stimulus and verdict
	initial begin
		int g;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		ax             = '0;
		ay             = '0;
		bx             = '0;
		by_coord       = '0;
		cx             = '0;
		cy             = '0;
		cfg_valid      = 1'b0;
		grid_max       = '0;
		triangles_sent = 0;
		grid_writes    = 0;
		set_idling(0, 0);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset grid of 99: full cover, both coordinate extremes
		send_triangle(0, 0, 200 * Q, 0, 0, 200 * Q);
		send_triangle(-524288, -524288, -524288, -524288, -524288, -524288);
		send_triangle(524287, 524287, 524287, 524287, 524287, 524287);

		// smallest non-empty grid
		write_grid(1);
		send_triangle(1 * Q, 1 * Q, 1 * Q, 1 * Q, 1 * Q, 1 * Q);
		send_triangle(2 * Q, 2 * Q, 3 * Q, 2 * Q, 2 * Q, 3 * Q);

		// empty grid walk
		write_grid(0);
		send_triangle(0, 0, 200 * Q, 0, 0, 200 * Q);
		send_random_triangle(4);

		// directed shapes on a small grid
		write_grid(8);
		set_idling(49, 0);
		send_triangle(1 * Q, 1 * Q, 8 * Q, 1 * Q, 1 * Q, 8 * Q);
		send_triangle(1 * Q, 1 * Q, 1 * Q, 8 * Q, 8 * Q, 1 * Q);
		send_triangle(0, 0, 1 * Q, 1 * Q, 2 * Q, 2 * Q);
		send_triangle(3 * Q, 4 * Q, 5 * Q, 4 * Q, 6 * Q, 4 * Q);
		send_triangle(4 * Q, 4 * Q, 4 * Q, 4 * Q, 4 * Q, 4 * Q);
		send_triangle(4 * Q + Q / 2, 4 * Q + Q / 2, 4 * Q + Q / 2, 4 * Q + Q / 2,
			4 * Q + Q / 2, 4 * Q + Q / 2);
		send_triangle(384, 64, 1984, 640, 800, 2022);
		send_triangle(-10 * Q, -10 * Q, -2 * Q, -1 * Q, -5 * Q, -8 * Q);
		send_triangle(-524288, -524288, 524287, -524288, 524287, 524287);
		send_triangle(-524288, -524288, 524287, 524287, -524288, 524287);
		send_triangle(-524288, 524287, 524287, -524288, 524287, 524287);
		send_triangle(8 * Q, 8 * Q, 1 * Q, 8 * Q, 8 * Q, 1 * Q);
		send_triangle(1 * Q, 1 * Q, 8 * Q, 8 * Q, 8 * Q + 1, 8 * Q);

		// random phases, cycling the idling modes
		for (int phase = 0; phase < 8; phase++) begin
			g = (phase == 0) ? 2 : int'($urandom_range(1, 20));
			write_grid(g);
			case (phase % 4)
				0: set_idling(0, 0);
				1: set_idling(49, 0);
				2: set_idling(0, 49);
				default: set_idling(35, 35);
			endcase
			for (int n = 0; n < 12; n++)
				send_random_triangle(g);
		end

		// largest grid: full cover, then one random
		write_grid(255);
		set_idling(35, 35);
		send_triangle(0, 0, 600 * Q, 0, 0, 600 * Q);
		send_random_triangle(255);

		wait_drained();
		repeat (20) @(negedge clk);
		$display("Sent %0d triangles, checked %0d counts across %0d grid writes",
			triangles_sent, counts_seen, grid_writes);
		$display("Grids from 0 to 255, with sender gaps and receiver stalls.");
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/tlpc_pkg.sv
src/tlpc_scan.sv
src/tlpc_edge.sv
src/tlpc_count.sv
src/triangle_lattice_point_counter.sv
src/tlpc_checker.sv
tb/lattice_count_checker.sv
tb/tb_triangle_lattice_point_counter.sv
